### rtl/imh_pkg.sv
// Shared types and constants for the indexed min-heap unit.
// No dependencies.
package imh_pkg;

  localparam int MaxEntriesDef = 1024;
  localparam int IdW           = 10;
  localparam int KeyW          = 32;
  localparam int SizeW         = 11;
  localparam int NumIds        = 1 << IdW;

  typedef enum logic [2:0] {
    REQ_LOAD  = 3'd0,
    REQ_BUILD = 3'd1,
    REQ_POP   = 3'd2,
    REQ_UPD   = 3'd3,
    REQ_PEN   = 3'd4,
    REQ_ERASE = 3'd5
  } req_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_SKIPPED = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]      req_type;
    logic [IdW-1:0]  entry_id;
    logic [KeyW-1:0] key_value;
    logic            on_border;
  } req_t;

  typedef struct packed {
    logic [IdW-1:0]   out_entry;
    logic [KeyW-1:0]  out_key;
    logic [SizeW-1:0] heap_size;
    logic [1:0]       status;
  } res_t;

endpackage

### rtl/indexed_min_heap_unit.sv
// Indexed min-heap unit top level: border-mode register and heap sequencer.
// Depends on imh_pkg and imh_engine.
//
// Usage: drive req_i and pulse start_i while busy_o is low; the transaction
// is taken at that edge and busy_o rises on the next cycle. The result is
// shown on res_o with done_o high for exactly one cycle; the receiver cannot
// stall it. busy_o falls the cycle after done_o.
// Requests run as a chain of sequencer states; each memory has a write
// port and a registered read port. Load, or a request on an absent entry,
// probes the position, key and slot memories; pop of an empty heap reads
// no memory; update/penalize/erase/pop sift the moved entry down or up one
// level at a time; build sifts down each interior slot, last one first.
// cfg_we_i writes include_border from cfg_wdata_i; write only while idle.
// Reset empties the heap and sets include_border to 1; memory contents are
// not cleared, and a stale position entry never passes the presence check.
module indexed_min_heap_unit #(
  parameter int MAX_ENTRIES = imh_pkg::MaxEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  imh_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output imh_pkg::res_t res_o,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i
);
  import imh_pkg::*;

  logic incl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      incl_q <= 1'b1;
    end else if (cfg_we_i) begin
      incl_q <= cfg_wdata_i;
    end
  end

  imh_engine #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .req_i        (req_i),
    .incl_border_i(incl_q),
    .busy_o       (busy_o),
    .done_o       (done_o),
    .res_o        (res_o)
  );

endmodule

### rtl/imh_engine.sv
// Heap sequencer: slot, position and key memories plus the sift controller.
// Depends on imh_pkg.
module imh_engine #(
  parameter int MAX_ENTRIES = imh_pkg::MaxEntriesDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  imh_pkg::req_t req_i,
  input  logic          incl_border_i,
  output logic          busy_o,
  output logic          done_o,
  output imh_pkg::res_t res_o
);
  import imh_pkg::*;

  localparam int SW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [21:0] {
    S_IDLE = 22'(1 << 0),  S_PR0 = 22'(1 << 1),  S_PR1 = 22'(1 << 2),
    S_PR2  = 22'(1 << 3),  S_LM0 = 22'(1 << 4),  S_LM1 = 22'(1 << 5),
    S_LM2  = 22'(1 << 6),  S_TP0 = 22'(1 << 7),  S_TP1 = 22'(1 << 8),
    S_TP2  = 22'(1 << 9),  S_SD0 = 22'(1 << 10), S_SD1 = 22'(1 << 11),
    S_SD2  = 22'(1 << 12), S_SD3 = 22'(1 << 13), S_SU0 = 22'(1 << 14),
    S_SU1  = 22'(1 << 15), S_SU2 = 22'(1 << 16), S_FIN = 22'(1 << 17),
    S_BL0  = 22'(1 << 18), S_DONE = 22'(1 << 19), S_SP0 = 22'(1 << 20),
    S_SP1  = 22'(1 << 21)
  } state_e;

  logic [IdW-1:0]  se_mem [MAX_ENTRIES+1];
  logic [SW-1:0]   es_mem [NumIds];
  logic [KeyW-1:0] ek_mem [NumIds];

  logic [IdW-1:0]  se_rd_q;
  logic [SW-1:0]   es_rd_q;
  logic [KeyW-1:0] ek_rd_q;

  logic            se_we, es_we, ek_we;
  logic [SW-1:0]   se_wa, se_ra, es_wd;
  logic [IdW-1:0]  se_wd, es_wa, es_ra, ek_wa, ek_ra;
  logic [KeyW-1:0] ek_wd;

  always_ff @(posedge clk_i) begin
    if (se_we) se_mem[se_wa] <= se_wd;
    se_rd_q <= se_mem[se_ra];
  end

  always_ff @(posedge clk_i) begin
    if (es_we) es_mem[es_wa] <= es_wd;
    es_rd_q <= es_mem[es_ra];
  end

  always_ff @(posedge clk_i) begin
    if (ek_we) ek_mem[ek_wa] <= ek_wd;
    ek_rd_q <= ek_mem[ek_ra];
  end

  state_e          state_q, state_d;
  logic [SW-1:0]   count_q, count_d;
  req_t            rq_q, rq_d;
  logic [SW-1:0]   s_q, s_d, c_q, c_d, ls_q, ls_d, bld_q, bld_d;
  logic [KeyW-1:0] old_q, old_d, mvk_q, mvk_d, ck_q, ck_d, okey_q, okey_d;
  logic [IdW-1:0]  mve_q, mve_d, ce_q, ce_d, ce2_q, ce2_d, pe_q, pe_d;
  logic [IdW-1:0]  oent_q, oent_d;
  status_e         stat_q, stat_d;

  logic [SW:0]     child;
  logic            pres, in_range, use2;
  logic [IdW-1:0]  be;
  logic [KeyW-1:0] bk;
  logic [SW-1:0]   bc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rq_q   <= rq_d;   s_q    <= s_d;    c_q   <= c_d;   ls_q  <= ls_d;
    bld_q  <= bld_d;  old_q  <= old_d;  mvk_q <= mvk_d; ck_q  <= ck_d;
    okey_q <= okey_d; mve_q  <= mve_d;  ce_q  <= ce_d;  ce2_q <= ce2_d;
    pe_q   <= pe_d;   oent_q <= oent_d; stat_q <= stat_d;
  end

  assign child    = {s_q, 1'b0};
  assign in_range = 32'(rq_q.entry_id) < 32'(MAX_ENTRIES);
  assign pres     = in_range && (s_q != '0) && (s_q <= count_q) && (se_rd_q == rq_q.entry_id);
  assign use2     = (c_q < count_q) && (ck_q > ek_rd_q);
  assign be       = use2 ? ce2_q : ce_q;
  assign bk       = use2 ? ek_rd_q : ck_q;
  assign bc       = use2 ? c_q + SW'(1) : c_q;

  always_comb begin
    state_d = state_q; count_d = count_q; rq_d = rq_q;
    s_d = s_q; c_d = c_q; ls_d = ls_q; bld_d = bld_q;
    old_d = old_q; mvk_d = mvk_q; ck_d = ck_q; okey_d = okey_q;
    mve_d = mve_q; ce_d = ce_q; ce2_d = ce2_q; pe_d = pe_q;
    oent_d = oent_q; stat_d = stat_q;
    se_we = 1'b0; se_wa = '0; se_wd = '0; se_ra = '0;
    es_we = 1'b0; es_wa = '0; es_wd = '0; es_ra = '0;
    ek_we = 1'b0; ek_wa = '0; ek_wd = '0; ek_ra = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          rq_d   = req_i;
          oent_d = req_i.entry_id;
          okey_d = '0;
          stat_d = ST_OK;
          case (req_i.req_type)
            REQ_LOAD, REQ_UPD, REQ_PEN, REQ_ERASE: state_d = S_PR0;
            REQ_BUILD: begin
              bld_d   = count_q >> 1;
              state_d = S_BL0;
            end
            REQ_POP: begin
              if (count_q == '0) begin
                stat_d  = ST_EMPTY;
                state_d = S_DONE;
              end else begin
                state_d = S_TP0;
              end
            end
            default: state_d = S_DONE;
          endcase
        end
      end
      S_PR0: begin
        es_ra   = rq_q.entry_id;
        ek_ra   = rq_q.entry_id;
        state_d = S_PR1;
      end
      S_PR1: begin
        s_d     = es_rd_q;
        old_d   = ek_rd_q;
        se_ra   = es_rd_q;
        state_d = S_PR2;
      end
      S_PR2: begin
        state_d = S_DONE;
        ek_wa   = rq_q.entry_id;
        mve_d   = rq_q.entry_id;
        case (rq_q.req_type)
          REQ_LOAD: begin
            if ((!incl_border_i && rq_q.on_border) || !in_range) begin
              stat_d = ST_SKIPPED;
            end else if (pres) begin
              ek_we = 1'b1;
              ek_wd = rq_q.key_value;
            end else if (32'(count_q) >= 32'(MAX_ENTRIES)) begin
              stat_d = ST_SKIPPED;
            end else begin
              count_d = count_q + SW'(1);
              se_we = 1'b1; se_wa = count_d; se_wd = rq_q.entry_id;
              es_we = 1'b1; es_wa = rq_q.entry_id; es_wd = count_d;
              ek_we = 1'b1; ek_wd = rq_q.key_value;
            end
          end
          REQ_UPD: begin
            if (!pres) begin
              stat_d = ST_ABSENT;
            end else begin
              ek_we   = 1'b1;
              ek_wd   = rq_q.key_value;
              mvk_d   = rq_q.key_value;
              state_d = (rq_q.key_value > old_q) ? S_SD0 : S_SU0;
            end
          end
          REQ_PEN: begin
            if (!pres) begin
              stat_d = ST_ABSENT;
            end else begin
              ek_we   = 1'b1;
              ek_wd   = '1;
              mvk_d   = '1;
              state_d = S_SD0;
            end
          end
          default: begin
            if (!pres) begin
              stat_d = ST_ABSENT;
            end else if (s_q == count_q) begin
              count_d = count_q - SW'(1);
            end else begin
              ls_d    = count_q;
              count_d = count_q - SW'(1);
              state_d = S_LM0;
            end
          end
        endcase
      end
      S_TP0: begin
        se_ra   = SW'(1);
        state_d = S_TP1;
      end
      S_TP1: begin
        oent_d  = se_rd_q;
        ek_ra   = se_rd_q;
        state_d = S_TP2;
      end
      S_TP2: begin
        okey_d  = ek_rd_q;
        s_d     = SW'(1);
        ls_d    = count_q;
        count_d = count_q - SW'(1);
        state_d = S_LM0;
      end
      S_BL0: begin
        if (bld_q == '0) begin
          state_d = S_DONE;
        end else begin
          s_d     = bld_q;
          ls_d    = bld_q;
          state_d = S_LM0;
        end
      end
      S_LM0: begin
        se_ra   = ls_q;
        state_d = S_LM1;
      end
      S_LM1: begin
        mve_d   = se_rd_q;
        ek_ra   = se_rd_q;
        state_d = S_LM2;
      end
      S_LM2: begin
        mvk_d = ek_rd_q;
        if (rq_q.req_type == REQ_ERASE && !(ek_rd_q > old_q)) state_d = S_SU0;
        else                                                  state_d = S_SD0;
      end
      S_SD0: begin
        if (child > {1'b0, count_q}) begin
          state_d = S_FIN;
        end else begin
          c_d     = child[SW-1:0];
          se_ra   = child[SW-1:0];
          state_d = S_SD1;
        end
      end
      S_SD1: begin
        ce_d    = se_rd_q;
        ek_ra   = se_rd_q;
        se_ra   = (c_q < count_q) ? c_q + SW'(1) : c_q;
        state_d = S_SD2;
      end
      S_SD2: begin
        ck_d    = ek_rd_q;
        ce2_d   = se_rd_q;
        ek_ra   = se_rd_q;
        state_d = S_SD3;
      end
      S_SD3: begin
        if (mvk_q > bk) begin
          se_we = 1'b1; se_wa = s_q; se_wd = be;
          es_we = 1'b1; es_wa = be;  es_wd = s_q;
          s_d     = bc;
          state_d = S_SD0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_SU0: begin
        if (s_q <= SW'(1)) begin
          state_d = S_FIN;
        end else begin
          se_ra   = s_q >> 1;
          state_d = S_SU1;
        end
      end
      S_SU1: begin
        pe_d    = se_rd_q;
        ek_ra   = se_rd_q;
        state_d = S_SU2;
      end
      S_SU2: begin
        if (ek_rd_q > mvk_q) begin
          se_we = 1'b1; se_wa = s_q;  se_wd = pe_q;
          es_we = 1'b1; es_wa = pe_q; es_wd = s_q;
          s_d     = s_q >> 1;
          state_d = S_SU0;
        end else begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        se_we = 1'b1; se_wa = s_q;   se_wd = mve_q;
        es_we = 1'b1; es_wa = mve_q; es_wd = s_q;
        if (rq_q.req_type == REQ_BUILD) begin
          bld_d   = bld_q - SW'(1);
          state_d = S_BL0;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o          = (state_q != S_IDLE);
  assign done_o          = (state_q == S_DONE);
  assign res_o.out_entry = oent_q;
  assign res_o.out_key   = okey_q;
  assign res_o.heap_size = SizeW'(count_q);
  assign res_o.status    = stat_q;

endmodule
